// ----- hdl/tat_pkg.sv -----
// Shared types, constants and the build-time Celsius conversion for the thermistor block.
package tat_pkg;

    localparam int CELSIUS_W = 9;
    localparam int FAHR_W    = 10;
    localparam int LEVEL_W   = 3;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_W     = 32;

    localparam int T_MIN = -40;
    localparam int T_MAX = 150;

    localparam longint unsigned LN2_Q30 = 64'd744261118;

    typedef logic signed [CELSIUS_W-1:0] t_celsius;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OK_MIN      = 3'd0,
        CFG_OK_MAX      = 3'd1,
        CFG_NORMAL_LOW  = 3'd2,
        CFG_NORMAL_HIGH = 3'd3,
        CFG_CRIT_ABOVE  = 3'd4
    } t_cfg_idx;

    typedef enum logic [LEVEL_W-1:0] {
        LVL_FREEZING = 3'd0,
        LVL_COLD     = 3'd1,
        LVL_NORMAL   = 3'd2,
        LVL_WARM     = 3'd3,
        LVL_HOT      = 3'd4,
        LVL_VERY_HOT = 3'd5,
        LVL_CRITICAL = 3'd6
    } t_level;

    // Base-2 logarithm in Q28: integer part from the leading one, fraction by squaring.
    function automatic longint unsigned log2_q28(input longint unsigned v);
        int unsigned k;
        longint unsigned y;
        longint unsigned frac;
        int i;
        k    = 0;
        frac = 0;
        while (k < 62 && (v >> (k + 1)) != 0) begin
            k++;
        end
        if (k <= 30) begin
            y = v << (30 - k);
        end else begin
            y = v >> (k - 30);
        end
        for (i = 27; i >= 0; i--) begin
            y = (y * y) >> 30;
            if (y >= (64'd2 << 30)) begin
                y    = y >> 1;
                frac = frac | (64'd1 << i);
            end
        end
        return (64'(k) << 28) | frac;
    endfunction

    // Restoring shift-subtract division, evaluated only while the table is built.
    function automatic longint unsigned udiv64(input longint unsigned n,
                                               input longint unsigned d);
        logic [64:0] rem;
        logic [63:0] q;
        int i;
        rem = '0;
        q   = '0;
        for (i = 63; i >= 0; i--) begin
            rem = {rem[63:0], n[i]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Beta equation over the pull-up divider, clamped and truncated toward zero.
    function automatic t_celsius celsius_of_code(input int unsigned a, input int unsigned bits);
        longint unsigned full;
        longint unsigned mag;
        longint unsigned lnm;
        longint unsigned term;
        longint unsigned base;
        longint unsigned inv;
        longint unsigned y;
        longint l;
        longint z;
        bit neg;
        full = (64'd1 << bits) - 64'd1;
        if (a == 0 || 64'(a) >= full) begin
            return CELSIUS_W'(T_MIN);
        end
        l = longint'(log2_q28(64'd7980 * 64'(a))) -
            longint'(log2_q28(64'd1682 * (full - 64'(a))));
        neg  = (l < 0);
        mag  = neg ? 64'(-l) : 64'(l);
        lnm  = (mag * LN2_Q30) >> 30;
        term = (lnm << 20) / 64'd3950;
        base = (64'd20 << 48) / 64'd5863;
        if (neg) begin
            if (term >= base) begin
                return CELSIUS_W'(T_MIN);
            end
            inv = base - term;
        end else begin
            inv = base + term;
        end
        y = udiv64(64'd20 << 56, inv);
        z = longint'(y) - longint'(5463 * 256);
        if (z < longint'(T_MIN * 5120)) begin
            z = longint'(T_MIN * 5120);
        end
        if (z > longint'(T_MAX * 5120)) begin
            z = longint'(T_MAX * 5120);
        end
        z = z / 64'sd5120;
        return CELSIUS_W'(z);
    endfunction

endpackage

// ----- hdl/tat_rom.sv -----
// Code-to-Celsius lookup ROM with a registered read port.
module tat_rom import tat_pkg::*; #(
    parameter int ADC_BITS = 10
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [ADC_BITS-1:0] i_addr,
    output t_celsius            o_data
);

    localparam int DEPTH = 1 << ADC_BITS;

    typedef t_celsius t_rom_array [DEPTH];

    function automatic t_rom_array build_rom();
        t_rom_array rom;
        for (int i = 0; i < DEPTH; i++) begin
            rom[i] = celsius_of_code(i, ADC_BITS);
        end
        return rom;
    endfunction

    localparam t_rom_array CEL_ROM = build_rom();

    t_celsius r_data;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= CEL_ROM[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

// ----- hdl/thermistor_averaged_temperature.sv -----
// Top level: sample ring, running mean, Celsius lookup and result formatting.
// A result is valid once its request has passed the ring, sum, mean, ROM, Fahrenheit and output registers.
// Throughput: one request per cycle unless the output stalls, set by the read-modify-write
// of the ring memory (one read and one write port) and the single-port conversion ROM.
// Reset (i_rst_n low, synchronous) clears the ring through per-entry valid bits, the running
// sum, write slot, first-sample flag and pipeline valids, and sets the configuration defaults.
module thermistor_averaged_temperature import tat_pkg::*; #(
    parameter int TAPS     = 5,
    parameter int ADC_BITS = 10
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write port.
    input  logic                                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                  i_cfg_idx,
    input  logic [CFG_W-1:0]                      i_cfg_data,
    // Sample stream.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata fields from bit 0: adc_sample, then zero padding.
    input  logic [((ADC_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // Result stream.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata fields from bit 0: temp_celsius, temp_fahrenheit, level_class,
    // is_normal, is_critical, sensor_ok, then zero padding.
    output logic [OUT_W-1:0]                      m_axis_tdata
);

    // The ring holds TAPS samples; the running sum covers every entry.
    localparam int SLOT_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int SUM_W   = $clog2(TAPS * ((1 << ADC_BITS) - 1) + 1);
    // Mean by reciprocal multiply: the estimate is exact or one short.
    localparam int SH      = SUM_W;
    localparam int RECIP_W = SH + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam longint unsigned RECIP = (64'd1 << SH) / TAPS;
    localparam int CMP_W   = (ADC_BITS > CFG_W) ? ADC_BITS : CFG_W;
    // Fahrenheit: 9*c+160 fits 12 signed bits; divide by five with a Q18 reciprocal.
    localparam int FV_W    = 12;
    localparam int FMAG_W  = 11;
    localparam int FPROD_W = 27;
    localparam int FIVE_RECIP = 52429;
    localparam int FIVE_SH    = 18;
    localparam int PAD_W   = OUT_W - CELSIUS_W - FAHR_W - LEVEL_W - 3;

    // The whole pipeline moves together; it stalls only when a finished
    // result sits in the output register and the consumer is not taking it.
    logic adv;
    logic in_fire;
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign in_fire       = s_axis_tvalid && adv;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_ok_min;
    logic [CFG_W-1:0] r_ok_max;
    t_celsius         r_normal_low;
    t_celsius         r_normal_high;
    t_celsius         r_crit_above;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok_min      <= CFG_W'(21);
            r_ok_max      <= CFG_W'(1002);
            r_normal_low  <= CELSIUS_W'(20);
            r_normal_high <= CELSIUS_W'(80);
            r_crit_above  <= CELSIUS_W'(100);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OK_MIN:      r_ok_min      <= i_cfg_data;
                CFG_OK_MAX:      r_ok_max      <= i_cfg_data;
                CFG_NORMAL_LOW:  r_normal_low  <= i_cfg_data[CELSIUS_W-1:0];
                CFG_NORMAL_HIGH: r_normal_high <= i_cfg_data[CELSIUS_W-1:0];
                CFG_CRIT_ABOVE:  r_crit_above  <= i_cfg_data[CELSIUS_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: accept the sample and issue the read of the slot it replaces.
    // ------------------------------------------------------------------
    logic [ADC_BITS-1:0] in_raw;
    assign in_raw = s_axis_tdata[ADC_BITS-1:0];

    logic [ADC_BITS-1:0] ring [TAPS];
    logic [TAPS-1:0]     r_ring_vld;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_primed;

    logic                r1_v;
    logic [ADC_BITS-1:0] r1_raw;
    logic [SLOT_W-1:0]   r1_slot;
    logic                r1_first;
    logic                r1_sok;
    logic                r1_fwd;
    logic [ADC_BITS-1:0] r1_fwd_data;
    logic                r1_old_vld;
    logic [ADC_BITS-1:0] r_rd_data;

    logic [SLOT_W-1:0] n_slot;
    assign n_slot = (r_slot == SLOT_W'(TAPS - 1)) ? '0 : r_slot + SLOT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot   <= '0;
            r_primed <= 1'b0;
            r1_v     <= 1'b0;
        end else if (adv) begin
            r1_v <= in_fire;
            if (in_fire) begin
                r_slot   <= n_slot;
                r_primed <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_raw      <= in_raw;
            r1_slot     <= r_slot;
            r1_first    <= !r_primed;
            r1_sok      <= (CMP_W'(in_raw) >= CMP_W'(r_ok_min)) &&
                           (CMP_W'(in_raw) <= CMP_W'(r_ok_max));
            // The item one stage ahead writes the same slot on this edge, so
            // the memory would still hand back the older value.
            r1_fwd      <= r1_v && (r1_slot == r_slot);
            r1_fwd_data <= r1_raw;
            r1_old_vld  <= r_ring_vld[r_slot];
            r_rd_data   <= ring[r_slot];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: write the new sample back and update the running sum.
    // ------------------------------------------------------------------
    logic [ADC_BITS-1:0] old_sample;
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    n_sum;

    always_comb begin
        if (r1_fwd) begin
            old_sample = r1_fwd_data;
        end else if (r1_old_vld) begin
            old_sample = r_rd_data;
        end else begin
            old_sample = '0;
        end
        n_sum = r_sum - SUM_W'(old_sample) + SUM_W'(r1_raw);
    end

    always_ff @(posedge i_clk) begin
        if (adv && r1_v) begin
            ring[r1_slot] <= r1_raw;
        end
    end

    logic                r2_v;
    logic [ADC_BITS-1:0] r2_raw;
    logic                r2_first;
    logic                r2_sok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_ring_vld <= '0;
            r2_v       <= 1'b0;
        end else if (adv) begin
            r2_v <= r1_v;
            if (r1_v) begin
                r_sum               <= n_sum;
                r_ring_vld[r1_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_raw   <= r1_raw;
            r2_first <= r1_first;
            r2_sok   <= r1_sok;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: reciprocal product of the sum.
    // ------------------------------------------------------------------
    logic                r3_v;
    logic [PROD_W-1:0]   r3_prod;
    logic [SUM_W-1:0]    r3_sum;
    logic [ADC_BITS-1:0] r3_raw;
    logic                r3_first;
    logic                r3_sok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (adv) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_prod  <= PROD_W'(r_sum) * PROD_W'(RECIP);
            r3_sum   <= r_sum;
            r3_raw   <= r2_raw;
            r3_first <= r2_first;
            r3_sok   <= r2_sok;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: correct the quotient and pick the ROM address.
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] q_est;
    logic [SUM_W-1:0] q_rem;
    logic [SUM_W-1:0] q_mean;

    always_comb begin
        q_est  = SUM_W'(r3_prod >> SH);
        q_rem  = r3_sum - SUM_W'(q_est * SUM_W'(TAPS));
        q_mean = (q_rem >= SUM_W'(TAPS)) ? q_est + SUM_W'(1) : q_est;
    end

    logic                r4_v;
    logic [ADC_BITS-1:0] r4_code;
    logic                r4_sok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (adv) begin
            r4_v <= r3_v;
        end
    end

    // The very first sample after reset is converted on its own.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_code <= r3_first ? r3_raw : q_mean[ADC_BITS-1:0];
            r4_sok  <= r3_sok;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: Celsius lookup.
    // ------------------------------------------------------------------
    t_celsius r5_cel;
    logic     r5_v;
    logic     r5_sok;

    tat_rom #(
        .ADC_BITS(ADC_BITS)
    ) u_rom (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_addr(r4_code),
        .o_data(r5_cel)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (adv) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_sok <= r4_sok;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: Fahrenheit product, level band and flags.
    // ------------------------------------------------------------------
    logic signed [FV_W-1:0] fv;
    logic [FMAG_W-1:0]      fv_mag;
    t_level                 level;

    always_comb begin
        fv     = (FV_W'(r5_cel) <<< 3) + FV_W'(r5_cel) + FV_W'(160);
        fv_mag = fv[FV_W-1] ? FMAG_W'(-fv) : FMAG_W'(fv);
        if (r5_cel < 0) begin
            level = LVL_FREEZING;
        end else if (r5_cel < CELSIUS_W'(20)) begin
            level = LVL_COLD;
        end else if (r5_cel < CELSIUS_W'(40)) begin
            level = LVL_NORMAL;
        end else if (r5_cel < CELSIUS_W'(60)) begin
            level = LVL_WARM;
        end else if (r5_cel < CELSIUS_W'(80)) begin
            level = LVL_HOT;
        end else if (r5_cel < CELSIUS_W'(100)) begin
            level = LVL_VERY_HOT;
        end else begin
            level = LVL_CRITICAL;
        end
    end

    logic               r6_v;
    t_celsius           r6_cel;
    logic [FPROD_W-1:0] r6_fprod;
    logic               r6_fneg;
    t_level             r6_level;
    logic               r6_normal;
    logic               r6_crit;
    logic               r6_sok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (adv) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_cel    <= r5_cel;
            r6_fprod  <= FPROD_W'(fv_mag) * FPROD_W'(FIVE_RECIP);
            r6_fneg   <= fv[FV_W-1];
            r6_level  <= level;
            r6_normal <= (r5_cel >= r_normal_low) && (r5_cel <= r_normal_high);
            r6_crit   <= (r5_cel > r_crit_above);
            r6_sok    <= r5_sok;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: output register.
    // ------------------------------------------------------------------
    logic [FAHR_W-1:0] fahr_mag;
    logic [FAHR_W-1:0] fahr;

    always_comb begin
        fahr_mag = FAHR_W'(r6_fprod >> FIVE_SH);
        fahr     = r6_fneg ? FAHR_W'(0) - fahr_mag : fahr_mag;
    end

    logic             r_out_v;
    logic [OUT_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= {PAD_W'(0), r6_sok, r6_crit, r6_normal, r6_level, fahr, r6_cel};
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;

endmodule
